// File: rtl/cfsm_pkg.sv
`default_nettype none
package cfsm_pkg;

	localparam int HIST_BINS = 256;
	localparam int TS_W      = 48;
	localparam int ID_W      = 29;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] SC_FRAME_COUNT  = 3'd0;
	localparam logic [2:0] SC_MIN_LENGTH   = 3'd1;
	localparam logic [2:0] SC_MAX_LENGTH   = 3'd2;
	localparam logic [2:0] SC_MIN_INTERVAL = 3'd3;
	localparam logic [2:0] SC_MAX_INTERVAL = 3'd4;
	localparam logic [2:0] SC_INT_TOTAL    = 3'd5;
	localparam logic [2:0] SC_LAST_TS      = 3'd6;
	localparam logic [2:0] SC_SEEN_ANY     = 3'd7;

	localparam logic [2:0] BY_MINIMUM = 3'd0;
	localparam logic [2:0] BY_MAXIMUM = 3'd1;
	localparam logic [2:0] BY_CHANGED = 3'd2;
	localparam logic [2:0] BY_FIRST   = 3'd3;
	localparam logic [2:0] BY_LAST    = 3'd4;
	localparam logic [2:0] BY_SEEN    = 3'd5;

	localparam logic [6:0] BYTE_BASE = 7'd16;
	localparam logic [6:0] BYTE_END  = 7'd80;

	localparam logic [47:0] MIN_INTERVAL_RESET = 48'h0000_7FFF_FFFF;
	localparam logic [8:0]  NO_MINIMUM         = 9'd256;

	localparam logic [1:0] CFG_TARGET_ID = 2'd0;

	typedef struct packed {
		logic [1:0]      kind;
		logic [3:0]      len;
		logic [63:0]     payload;
		logic [TS_W-1:0] ts;
		logic [11:0]     addr;
	} cfsm_op_t;

	typedef struct packed {
		logic sweep;
		logic start;
		logic busy;
	} cfsm_status_t;

endpackage
`default_nettype wire

// File: rtl/can_frame_statistics_monitor.sv
// CAN frame statistics monitor.
// Slave stream s_*: one request per beat. s_tuser carries the kind (frame,
// read statistic, clear). Frames with frame_id equal to target_id update the
// statistics; other frames and unused kinds are dropped at the front.
// Master stream m_*: one beat per read request, m_tdata the statistic value,
// m_tuser[0] set when the address maps to no statistic.
// The front classifies requests into a two-entry queue; the back executes one
// request at a time and takes none while busy_s1 is set: the histogram
// read-modify-write reads the bank as a request starts and updates and writes
// it back while busy. A read passes the queue, op_s1 and the output register.
// A stalled m_tready holds the result; the queue keeps taking requests until
// it fills, and later reads wait in the queue.
// After reset, and after each clear request, the histogram banks are zeroed
// by a pass over all 256 bins; s_tready stays low during it. target_id is written
// through the APB port at address 0 and survives a clear.
`default_nettype none
module can_frame_statistics_monitor #(
	parameter int PAYLOAD_BYTES = 8,
	parameter int COUNT_WIDTH   = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// frame_id[28:0], frame_len[32:29], payload[96:33], timestamp_us[144:97],
	// stat_address[156:145], zero [159:157]
	input  wire logic [159:0] s_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// read_data[63:0]
	output logic [63:0]       m_tdata,
	// bad_address[0]
	output logic [0:0]        m_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import cfsm_pkg::*;

	logic [ID_W-1:0] target_id_q;
	logic            q_valid, q_pop, bad;
	cfsm_op_t        q_op;
	cfsm_status_t    st;

	assign pready = 1'b1;
	assign prdata = (paddr[3:2] == CFG_TARGET_ID) ? 32'(target_id_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_id_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[3:2] == CFG_TARGET_ID) begin
			target_id_q <= pwdata[ID_W-1:0];
		end
	end

	cfsm_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_data  (s_tdata),
		.target_id(target_id_q),
		.st       (st),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	cfsm_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop),
		.st       (st),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_bad  (bad)
	);

	assign m_tuser = bad;

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st.sweep |-> !s_tready && !st.start)
		else $error("request taken during histogram clear");
	a_busy_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		st.start |=> st.busy && !st.start)
		else $error("back started two requests back to back");
	a_result_from_back: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st.busy))
		else $error("result appeared without an executed read");
endmodule
`default_nettype wire

// File: rtl/cfsm_ram.sv
`default_nettype none
module cfsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/cfsm_front.sv
`default_nettype none
module cfsm_front #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             in_kind,
	input  wire logic [159:0]           in_data,
	input  wire logic [28:0]            target_id,
	input  wire cfsm_pkg::cfsm_status_t st,
	output logic                        q_valid,
	output cfsm_pkg::cfsm_op_t          q_op,
	input  wire logic                   q_pop
);
	import cfsm_pkg::*;

	cfsm_op_t   op_q [2];
	cfsm_op_t   op_in;
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       keep, push;
	logic [3:0] len_raw;

	assign len_raw = in_data[32:29];

	always_comb begin
		op_in.kind    = in_kind;
		op_in.len     = (len_raw > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : len_raw;
		op_in.payload = in_data[96:33];
		op_in.ts      = in_data[144:97];
		op_in.addr    = in_data[156:145];
	end

	always_comb begin
		unique case (in_kind)
			KIND_FRAME: keep = (in_data[28:0] == target_id);
			KIND_READ:  keep = 1'b1;
			KIND_CLEAR: keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2) && !st.sweep;
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = op_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (q_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// File: rtl/cfsm_back.sv
`default_nettype none
module cfsm_back #(
	parameter int PAYLOAD_BYTES = 8,
	parameter int COUNT_WIDTH   = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire cfsm_pkg::cfsm_op_t q_op,
	output logic                    q_pop,
	output cfsm_pkg::cfsm_status_t  st,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             out_data,
	output logic                    out_bad
);
	import cfsm_pkg::*;

	localparam int NBITS = 8 * PAYLOAD_BYTES;
	localparam int BW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int IW    = $clog2(NBITS);
	localparam int CW    = COUNT_WIDTH;

	logic            busy_s1, sweep_q, start;
	cfsm_op_t        op_s1;
	logic [7:0]      sweep_cnt_q;
	logic            out_valid_q, out_bad_q;
	logic [63:0]     out_data_q;

	logic [CW-1:0]   frame_count_q;
	logic [3:0]      min_len_q, max_len_q;
	logic            seen_any_q;
	logic [TS_W-1:0] last_ts_q, min_int_q, max_int_q;
	logic [63:0]     int_total_q;
	logic [8:0]      byte_min_q [PAYLOAD_BYTES];
	logic [7:0]      byte_max_q [PAYLOAD_BYTES];
	logic            byte_seen_q [PAYLOAD_BYTES];
	logic [7:0]      first_q [PAYLOAD_BYTES];
	logic [7:0]      last_q [PAYLOAD_BYTES];
	logic [7:0]      changed_q [PAYLOAD_BYTES];
	logic [CW-1:0]   set_cnt_q [NBITS];
	logic [CW-1:0]   flip_cnt_q [NBITS];

	logic [CW-1:0]   hist_rd [PAYLOAD_BYTES];
	logic            frm, clr, rd;
	logic [TS_W-1:0] dlt;
	logic [64:0]     tot_sum;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_bad   = out_bad_q;

	assign start = q_valid && !sweep_q && !busy_s1 &&
		((q_op.kind != KIND_READ) || !out_valid_q || out_ready);
	assign q_pop = start;
	assign st    = '{sweep: sweep_q, start: start, busy: busy_s1};

	assign frm = busy_s1 && (op_s1.kind == KIND_FRAME);
	assign clr = busy_s1 && (op_s1.kind == KIND_CLEAR);
	assign rd  = busy_s1 && (op_s1.kind == KIND_READ);

	for (genvar c = 0; c < PAYLOAD_BYTES; c++) begin : g_bank
		logic          we;
		logic [7:0]    waddr, raddr;
		logic [CW-1:0] wdata;
		assign raddr = (q_op.kind == KIND_READ) ? q_op.addr[7:0] : q_op.payload[8*c +: 8];
		assign we    = sweep_q || (frm && (4'(c) < op_s1.len));
		assign waddr = sweep_q ? sweep_cnt_q : op_s1.payload[8*c +: 8];
		assign wdata = sweep_q ? '0 : ((&hist_rd[c]) ? hist_rd[c] : hist_rd[c] + 1'b1);
		cfsm_ram #(.WIDTH(CW), .DEPTH(HIST_BINS)) u_hist (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(wdata),
			.raddr(raddr),
			.rdata(hist_rd[c])
		);
	end

	always_ff @(posedge clk) begin
		if (start) op_s1 <= q_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= 8'd0;
		end else begin
			busy_s1 <= start;
			if (clr) begin
				sweep_q     <= 1'b1;
				sweep_cnt_q <= 8'd0;
			end else if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + 8'd1;
				if (&sweep_cnt_q) sweep_q <= 1'b0;
			end
		end
	end

	assign dlt     = (op_s1.ts >= last_ts_q) ? op_s1.ts - last_ts_q : last_ts_q - op_s1.ts;
	assign tot_sum = {1'b0, int_total_q} + 65'(dlt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			min_len_q     <= 4'(PAYLOAD_BYTES);
			max_len_q     <= 4'd0;
			seen_any_q    <= 1'b0;
			last_ts_q     <= '0;
			min_int_q     <= MIN_INTERVAL_RESET;
			max_int_q     <= '0;
			int_total_q   <= '0;
			for (int c = 0; c < PAYLOAD_BYTES; c++) begin
				byte_min_q[c]  <= NO_MINIMUM;
				byte_max_q[c]  <= 8'd0;
				byte_seen_q[c] <= 1'b0;
				first_q[c]     <= 8'd0;
				last_q[c]      <= 8'd0;
				changed_q[c]   <= 8'd0;
			end
			for (int n = 0; n < NBITS; n++) begin
				set_cnt_q[n]  <= '0;
				flip_cnt_q[n] <= '0;
			end
		end else if (clr) begin
			frame_count_q <= '0;
			min_len_q     <= 4'(PAYLOAD_BYTES);
			max_len_q     <= 4'd0;
			seen_any_q    <= 1'b0;
			last_ts_q     <= '0;
			min_int_q     <= MIN_INTERVAL_RESET;
			max_int_q     <= '0;
			int_total_q   <= '0;
			for (int c = 0; c < PAYLOAD_BYTES; c++) begin
				byte_min_q[c]  <= NO_MINIMUM;
				byte_max_q[c]  <= 8'd0;
				byte_seen_q[c] <= 1'b0;
				first_q[c]     <= 8'd0;
				last_q[c]      <= 8'd0;
				changed_q[c]   <= 8'd0;
			end
			for (int n = 0; n < NBITS; n++) begin
				set_cnt_q[n]  <= '0;
				flip_cnt_q[n] <= '0;
			end
		end else if (frm) begin
			if (!(&frame_count_q)) frame_count_q <= frame_count_q + 1'b1;
			if (seen_any_q) begin
				if (dlt > max_int_q) max_int_q <= dlt;
				if (dlt < min_int_q) min_int_q <= dlt;
				int_total_q <= tot_sum[64] ? '1 : tot_sum[63:0];
			end
			seen_any_q <= 1'b1;
			last_ts_q  <= op_s1.ts;
			if (op_s1.len > max_len_q) max_len_q <= op_s1.len;
			if (op_s1.len < min_len_q) min_len_q <= op_s1.len;
			for (int c = 0; c < PAYLOAD_BYTES; c++) begin
				if (4'(c) < op_s1.len) begin
					byte_seen_q[c] <= 1'b1;
					if (!byte_seen_q[c]) first_q[c] <= op_s1.payload[8*c +: 8];
					if ({1'b0, op_s1.payload[8*c +: 8]} < byte_min_q[c])
						byte_min_q[c] <= {1'b0, op_s1.payload[8*c +: 8]};
					if (op_s1.payload[8*c +: 8] > byte_max_q[c])
						byte_max_q[c] <= op_s1.payload[8*c +: 8];
					if (byte_seen_q[c])
						changed_q[c] <= changed_q[c] | (first_q[c] ^ op_s1.payload[8*c +: 8]);
					last_q[c] <= op_s1.payload[8*c +: 8];
				end
			end
			for (int n = 0; n < NBITS; n++) begin
				if (4'(n / 8) < op_s1.len) begin
					if (op_s1.payload[n] && !(&set_cnt_q[n]))
						set_cnt_q[n] <= set_cnt_q[n] + 1'b1;
					if (byte_seen_q[n / 8] && (last_q[n / 8][n % 8] != op_s1.payload[n])
						&& !(&flip_cnt_q[n]))
						flip_cnt_q[n] <= flip_cnt_q[n] + 1'b1;
				end
			end
		end
	end

	logic [63:0] rd_val;
	logic        rd_bad;
	logic [6:0]  boff;
	logic [2:0]  rb, rk, hb;
	logic [5:0]  ri;
	logic [11:0] a;

	assign a    = op_s1.addr;
	assign boff = a[6:0] - BYTE_BASE;
	assign rb   = boff[5:3];
	assign rk   = boff[2:0];
	assign ri   = a[6:1];
	assign hb   = a[10:8];

	always_comb begin
		rd_val = 64'd0;
		rd_bad = 1'b0;
		priority if (a[11:3] == 9'd0) begin
			unique case (a[2:0])
				SC_FRAME_COUNT:  rd_val = 64'(frame_count_q);
				SC_MIN_LENGTH:   rd_val = 64'(min_len_q);
				SC_MAX_LENGTH:   rd_val = 64'(max_len_q);
				SC_MIN_INTERVAL: rd_val = 64'(min_int_q);
				SC_MAX_INTERVAL: rd_val = 64'(max_int_q);
				SC_INT_TOTAL:    rd_val = int_total_q;
				SC_LAST_TS:      rd_val = 64'(last_ts_q);
				SC_SEEN_ANY:     rd_val = 64'(seen_any_q);
				default:         rd_val = 64'd0;
			endcase
		end else if (a[11:7] == 5'd0 && a[6:0] >= BYTE_BASE && a[6:0] < BYTE_END) begin
			if ({1'b0, rb} < 4'(PAYLOAD_BYTES)) begin
				unique case (rk)
					BY_MINIMUM: rd_val = 64'(byte_min_q[rb[BW-1:0]]);
					BY_MAXIMUM: rd_val = 64'(byte_max_q[rb[BW-1:0]]);
					BY_CHANGED: rd_val = 64'(changed_q[rb[BW-1:0]]);
					BY_FIRST:   rd_val = 64'(first_q[rb[BW-1:0]]);
					BY_LAST:    rd_val = 64'(last_q[rb[BW-1:0]]);
					BY_SEEN:    rd_val = 64'(byte_seen_q[rb[BW-1:0]]);
					default:    rd_bad = 1'b1;
				endcase
			end else begin
				rd_bad = 1'b1;
			end
		end else if (a[11:7] == 5'd1) begin
			if ({1'b0, ri} < 7'(NBITS))
				rd_val = a[0] ? 64'(flip_cnt_q[ri[IW-1:0]]) : 64'(set_cnt_q[ri[IW-1:0]]);
			else
				rd_bad = 1'b1;
		end else if (a[11]) begin
			if ({1'b0, hb} < 4'(PAYLOAD_BYTES)) rd_val = 64'(hist_rd[hb[BW-1:0]]);
			else rd_bad = 1'b1;
		end else begin
			rd_bad = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			out_data_q <= rd_val;
			out_bad_q  <= rd_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: verif/can_frame_statistics_monitor_test.sv
`default_nettype none
module can_frame_statistics_monitor_test;
	import cfsm_pkg::*;

	localparam int NBYTES    = 8;
	localparam int RAND_ITEMS = 900;

	typedef struct {
		logic [1:0]  kind;
		logic [28:0] id;
		logic [3:0]  len;
		logic [63:0] payload;
		logic [47:0] ts;
		logic [11:0] addr;
		bit          typed;
		logic [63:0] want_data;
		logic        want_bad;
	} request_t;

	typedef struct {
		logic [63:0] data;
		logic        bad;
	} stat_read_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	can_frame_statistics_monitor u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow statistics
	logic [28:0] cur_target;
	logic [31:0] sh_count;
	logic [3:0]  sh_min_len, sh_max_len;
	logic        sh_seen_any;
	logic [47:0] sh_last_ts, sh_min_int, sh_max_int;
	logic [63:0] sh_int_total;
	logic [8:0]  sh_bmin [NBYTES];
	logic [7:0]  sh_bmax [NBYTES];
	logic        sh_bseen [NBYTES];
	logic [7:0]  sh_first [NBYTES];
	logic [7:0]  sh_last [NBYTES];
	logic [7:0]  sh_changed [NBYTES];
	logic [31:0] sh_set_cnt [64];
	logic [31:0] sh_flip_cnt [64];
	logic [31:0] sh_hist [NBYTES*HIST_BINS];

	stat_read_t pending_reads[$];
	int         errors;
	int         rand_count;
	int         sink_wait;
	logic [7:0] pattern_bytes [NBYTES];

	function automatic logic [31:0] count_up(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void clear_shadow();
		sh_count = '0;
		sh_min_len = 4'd8;
		sh_max_len = '0;
		sh_seen_any = 1'b0;
		sh_last_ts = '0;
		sh_min_int = MIN_INTERVAL_RESET;
		sh_max_int = '0;
		sh_int_total = '0;
		for (int b = 0; b < NBYTES; b++) begin
			sh_bmin[b] = NO_MINIMUM;
			sh_bmax[b] = '0;
			sh_bseen[b] = 1'b0;
			sh_first[b] = '0;
			sh_last[b] = '0;
			sh_changed[b] = '0;
		end
		for (int i = 0; i < 64; i++) begin
			sh_set_cnt[i] = '0;
			sh_flip_cnt[i] = '0;
		end
		for (int i = 0; i < NBYTES*HIST_BINS; i++)
			sh_hist[i] = '0;
	endfunction

	function automatic void absorb_frame(logic [3:0] len_in, logic [63:0] pl, logic [47:0] ts);
		logic [3:0]  len;
		logic [47:0] gap;
		logic [64:0] sum;
		logic [7:0]  dat, flips;
		len = (len_in > 4'd8) ? 4'd8 : len_in;
		sh_count = count_up(sh_count);
		if (sh_seen_any) begin
			gap = (ts >= sh_last_ts) ? ts - sh_last_ts : sh_last_ts - ts;
			if (gap > sh_max_int) sh_max_int = gap;
			if (gap < sh_min_int) sh_min_int = gap;
			sum = {1'b0, sh_int_total} + {17'd0, gap};
			sh_int_total = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
		end
		sh_seen_any = 1'b1;
		sh_last_ts = ts;
		if (len > sh_max_len) sh_max_len = len;
		if (len < sh_min_len) sh_min_len = len;
		for (int c = 0; c < len; c++) begin
			dat = pl[8*c +: 8];
			if (!sh_bseen[c]) begin
				sh_bseen[c] = 1'b1;
				sh_first[c] = dat;
				sh_last[c] = dat;
			end
			if ({1'b0, dat} < sh_bmin[c]) sh_bmin[c] = {1'b0, dat};
			if (dat > sh_bmax[c]) sh_bmax[c] = dat;
			sh_hist[c*HIST_BINS + dat] = count_up(sh_hist[c*HIST_BINS + dat]);
			sh_changed[c] |= sh_first[c] ^ dat;
			flips = sh_last[c] ^ dat;
			for (int l = 0; l < 8; l++) begin
				if (dat[l]) sh_set_cnt[c*8+l] = count_up(sh_set_cnt[c*8+l]);
				if (flips[l]) sh_flip_cnt[c*8+l] = count_up(sh_flip_cnt[c*8+l]);
			end
			sh_last[c] = dat;
		end
	endfunction

	function automatic stat_read_t lookup_stat(logic [11:0] a);
		stat_read_t r;
		int b, k;
		r.data = '0;
		r.bad = 1'b0;
		if (a < 12'd8) begin
			case (a[2:0])
				SC_FRAME_COUNT:  r.data = {32'd0, sh_count};
				SC_MIN_LENGTH:   r.data = {60'd0, sh_min_len};
				SC_MAX_LENGTH:   r.data = {60'd0, sh_max_len};
				SC_MIN_INTERVAL: r.data = {16'd0, sh_min_int};
				SC_MAX_INTERVAL: r.data = {16'd0, sh_max_int};
				SC_INT_TOTAL:    r.data = sh_int_total;
				SC_LAST_TS:      r.data = {16'd0, sh_last_ts};
				default:         r.data = {63'd0, sh_seen_any};
			endcase
		end else if (a >= 12'd16 && a < 12'd80) begin
			b = (a - 16) >> 3;
			k = (a - 16) & 7;
			case (k[2:0])
				BY_MINIMUM: r.data = {55'd0, sh_bmin[b]};
				BY_MAXIMUM: r.data = {56'd0, sh_bmax[b]};
				BY_CHANGED: r.data = {56'd0, sh_changed[b]};
				BY_FIRST:   r.data = {56'd0, sh_first[b]};
				BY_LAST:    r.data = {56'd0, sh_last[b]};
				BY_SEEN:    r.data = {63'd0, sh_bseen[b]};
				default:    r.bad = 1'b1;
			endcase
		end else if (a >= 12'd128 && a < 12'd256) begin
			b = (a - 128) >> 1;
			r.data = {32'd0, a[0] ? sh_flip_cnt[b] : sh_set_cnt[b]};
		end else if (a >= 12'd2048) begin
			r.data = {32'd0, sh_hist[a - 2048]};
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic apb_write(logic [3:0] a, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_target = d[28:0];
	endtask

	task automatic send(request_t r);
		stat_read_t exp;
		int idle;
		idle = $urandom_range(0, 15) * int'($urandom_range(0, 3) != 0);
		if (idle != 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {3'd0, r.addr, r.ts, r.payload, r.len, r.id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (r.kind)
			KIND_FRAME: if (r.id == cur_target) absorb_frame(r.len, r.payload, r.ts);
			KIND_CLEAR: clear_shadow();
			KIND_READ: begin
				exp = lookup_stat(r.addr);
				if (r.typed && (exp.data !== r.want_data || exp.bad !== r.want_bad))
					report("typed row", exp.data, r.want_data);
				pending_reads = {pending_reads, exp};
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	function automatic request_t mk(logic [1:0] kind, logic [28:0] id, logic [3:0] len,
			logic [63:0] pl, logic [47:0] ts, logic [11:0] addr);
		request_t r;
		r.kind = kind; r.id = id; r.len = len; r.payload = pl; r.ts = ts; r.addr = addr;
		r.typed = 1'b0; r.want_data = '0; r.want_bad = 1'b0;
		return r;
	endfunction

	function automatic request_t rd(logic [11:0] addr, logic [63:0] d, logic bad);
		request_t r;
		r = mk(KIND_READ, '0, '0, '0, '0, addr);
		r.typed = 1'b1; r.want_data = d; r.want_bad = bad;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int sel;
		logic [63:0] pl;
		sel = $urandom_range(0, 99);
		for (int b = 0; b < 8; b++)
			pl[8*b +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom) : pattern_bytes[b] ^
				(8'd1 << $urandom_range(0, 7));
		r = mk(KIND_FRAME, cur_target, 4'($urandom_range(0, 8)), pl,
			sh_last_ts + 48'($urandom_range(0, 5000)) - 48'd1000, '0);
		if ($urandom_range(0, 30) == 0) r.ts = 48'({$urandom, $urandom});
		if ($urandom_range(0, 20) == 0) r.len = 4'($urandom_range(9, 15));
		if (sel < 50) begin
			if ($urandom_range(0, 7) == 0) r.id = 29'($urandom);
		end else if (sel < 95) begin
			r.kind = KIND_READ;
			case ($urandom_range(0, 4))
				0: r.addr = 12'($urandom_range(0, 15));
				1: r.addr = 12'($urandom_range(16, 127));
				2: r.addr = 12'($urandom_range(128, 255));
				3: r.addr = 12'($urandom_range(2048, 4095));
				default: r.addr = 12'($urandom);
			endcase
		end else if (sel < 97) begin
			r.kind = KIND_CLEAR;
		end else begin
			r.kind = 2'd3;
			r.id = 29'($urandom);
			r.addr = 12'($urandom);
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			sink_wait = 0;
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) sink_wait = $urandom_range(0, 15);
			else if (sink_wait != 0) sink_wait--;
			m_tready <= (sink_wait == 0);
		end
	end

	always @(posedge clk) begin
		stat_read_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				report("unexpected result", m_tdata, '0);
			end else begin
				exp = pending_reads.pop_front();
				if (m_tdata !== exp.data) report("read_data", m_tdata, exp.data);
				if (m_tuser[0] !== exp.bad)
					report("bad_address", 64'(m_tuser), 64'(exp.bad));
			end
		end
	end

	initial begin
		request_t rows[$];
		logic [28:0] targets[4];
		errors = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_FRAME;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_target = '0;
		clear_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write({CFG_TARGET_ID, 2'b00}, 32'h1FFF_FFFF);
		rows = {rows, rd(12'd0, 64'd0, 1'b0)};
		rows = {rows, rd(12'd1, 64'd8, 1'b0)};
		rows = {rows, rd(12'd3, 64'h7FFF_FFFF, 1'b0)};
		rows = {rows, rd(12'd16, 64'd256, 1'b0)};
		rows = {rows, rd(12'd8, 64'd0, 1'b1)};
		rows = {rows, rd(12'd22, 64'd0, 1'b1)};
		rows = {rows, rd(12'd2047, 64'd0, 1'b1)};
		rows = {rows, mk(KIND_FRAME, 29'h1FFF_FFFF, 4'd0, '1, 48'hFFFF_FFFF_FFFF, '0)};
		rows = {rows, mk(KIND_FRAME, 29'h0, 4'd8, '1, 48'd5, '0)};
		rows = {rows, mk(KIND_FRAME, 29'h1FFF_FFFF, 4'd2, 64'h00FF, 48'd0, '0)};
		rows = {rows, mk(KIND_FRAME, 29'h1FFF_FFFF, 4'd15, '1, 48'hFFFF_FFFF_FFFF, '0)};
		rows = {rows, mk(KIND_FRAME, 29'h1FFF_FFFF, 4'd8, '0, 48'h10, '0)};
		rows = {rows, mk(2'd3, 29'h1FFF_FFFF, 4'd8, '1, 48'h20, 12'd0)};
		for (int a = 0; a < 8; a++) rows = {rows, mk(KIND_READ, '0, '0, '0, '0, 12'(a))};
		rows = {rows, mk(KIND_READ, '0, '0, '0, '0, 12'd75)};
		rows = {rows, mk(KIND_READ, '0, '0, '0, '0, 12'd255)};
		rows = {rows, mk(KIND_READ, '0, '0, '0, '0, 12'd2303)};
		rows = {rows, mk(KIND_READ, '0, '0, '0, '0, 12'd4095)};
		rows = {rows, mk(KIND_CLEAR, '0, '0, '0, '0, '0)};
		rows = {rows, rd(12'd7, 64'd0, 1'b0)};
		foreach (rows[i]) send(rows[i]);
		drain();

		targets[0] = 29'h0; targets[1] = 29'h1FFF_FFFF;
		targets[2] = 29'h123; targets[3] = 29'h0ABC_DEF1;
		rand_count = 0;
		for (int ph = 0; ph < 4; ph++) begin
			apb_write({CFG_TARGET_ID, 2'b00}, {3'b111, targets[ph]});
			for (int b = 0; b < 8; b++) pattern_bytes[b] = 8'($urandom);
			for (int i = 0; i < RAND_ITEMS/4; i++) begin
				send(random_request());
				rand_count++;
			end
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
rtl/cfsm_pkg.sv
rtl/cfsm_ram.sv
rtl/cfsm_front.sv
rtl/cfsm_back.sv
rtl/can_frame_statistics_monitor.sv
verif/can_frame_statistics_monitor_test.sv
